### rtl/set_intersection_counter_core_assert.svh
// Assertion macros used by the core RTL file.
`ifndef SET_INTERSECTION_COUNTER_CORE_ASSERT_SVH
`define SET_INTERSECTION_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SIC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/sic_pkg.sv
`default_nettype none
package sic_pkg;
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 64;

    localparam logic [1:0] ACT_ADD_FIRST  = 2'd0;
    localparam logic [1:0] ACT_ADD_SECOND = 2'd1;
    localparam logic [1:0] ACT_REPORT     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_FWAIT,
        ST_SCAN_SELF,
        ST_SCAN_OTHER,
        ST_DONE
    } sic_state_t;
endpackage
`default_nettype wire

### rtl/set_intersection_counter_core.sv
// Channel   Ports                                   Transfer
// command   start, busy, action, key_value          start && !busy at clk edge
// result    done, first_size .. overflow_seen       done high for one cycle
//
// A key load (action 0 or 1) leaves busy low; the next command may follow
// at once. A report walks both stores with one 64-bit comparator and one
// read port per store: for each key of the first set it scans the earlier
// keys of that set and all of the second set, then for each key of the
// second set it scans its earlier keys; busy stays high throughout. rst_n
// clears the fill counts and the flag asynchronously; store contents need no
// reset. The receiver cannot stall: done and the result ports are valid for
// one cycle.
`default_nettype none
`include "set_intersection_counter_core_assert.svh"
module set_intersection_counter_core
    import sic_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [63:0] key_value,
    output logic             done,
    output logic [10:0]      first_size,
    output logic [10:0]      second_size,
    output logic [9:0]       first_repeats,
    output logic [9:0]       second_repeats,
    output logic [10:0]      common_count,
    output logic             overflow_seen
);
    localparam logic [FILL_W-1:0] FILL_CAP = FILL_W'(CAPACITY);

    sic_state_t state_reg, state_next;
    logic              phase_reg, phase_next;   // 0: walk first set, 1: second
    logic              src_reg, src_next;       // store feeding the comparator
    logic              pend_reg, pend_next;     // read issued last cycle
    logic [FILL_W-1:0] i_reg, i_next;
    logic [FILL_W-1:0] j_reg, j_next;
    logic [FILL_W-1:0] lim_reg, lim_next;
    logic [FILL_W-1:0] cnt_reg, cnt_next;
    logic [FILL_W-1:0] rank_reg, rank_next;
    logic [FILL_W-1:0] rep_a_reg, rep_a_next;
    logic [FILL_W-1:0] rep_b_reg, rep_b_next;
    logic [FILL_W-1:0] common_reg, common_next;
    logic [FILL_W-1:0] fill_a_reg, fill_a_next;
    logic [FILL_W-1:0] fill_b_reg, fill_b_next;
    logic              drop_reg, drop_next;
    logic [KEY_W-1:0]  key_reg, key_next;

    logic              we_a, we_b;
    logic [ADDR_W-1:0] rd_addr;
    logic [KEY_W-1:0]  rdata_a, rdata_b, rdata_sel;
    logic [FILL_W-1:0] cur_fill;
    logic              last_item;
    logic              scan_end;

    sic_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_first_store (
        .clk   (clk),
        .we    (we_a),
        .waddr (fill_a_reg[ADDR_W-1:0]),
        .wdata (key_value),
        .raddr (rd_addr),
        .rdata (rdata_a)
    );

    sic_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_second_store (
        .clk   (clk),
        .we    (we_b),
        .waddr (fill_b_reg[ADDR_W-1:0]),
        .wdata (key_value),
        .raddr (rd_addr),
        .rdata (rdata_b)
    );

    // Fetch reads the current key; scans read the running index.
    assign rd_addr   = (state_reg == ST_FETCH) ? i_reg[ADDR_W-1:0] : j_reg[ADDR_W-1:0];
    assign rdata_sel = src_reg ? rdata_b : rdata_a;
    assign cur_fill  = phase_reg ? fill_b_reg : fill_a_reg;
    assign last_item = ((i_reg + 1'b1) == cur_fill);
    assign scan_end  = (j_reg >= lim_reg) && !pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_a_reg <= '0;
            fill_b_reg <= '0;
            drop_reg   <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_a_reg <= fill_a_next;
            fill_b_reg <= fill_b_next;
            drop_reg   <= drop_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg  <= phase_next;
        src_reg    <= src_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        lim_reg    <= lim_next;
        cnt_reg    <= cnt_next;
        rank_reg   <= rank_next;
        rep_a_reg  <= rep_a_next;
        rep_b_reg  <= rep_b_next;
        common_reg <= common_next;
        key_reg    <= key_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        src_next    = src_reg;
        pend_next   = pend_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        lim_next    = lim_reg;
        cnt_next    = cnt_reg;
        rank_next   = rank_reg;
        rep_a_next  = rep_a_reg;
        rep_b_next  = rep_b_reg;
        common_next = common_reg;
        fill_a_next = fill_a_reg;
        fill_b_next = fill_b_reg;
        drop_next   = drop_reg;
        key_next    = key_reg;
        we_a        = 1'b0;
        we_b        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                pend_next = 1'b0;
                if (start)
                begin
                    case (action)
                        ACT_ADD_FIRST:
                        begin
                            if (fill_a_reg < FILL_CAP)
                            begin
                                we_a        = 1'b1;
                                fill_a_next = fill_a_reg + 1'b1;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        ACT_ADD_SECOND:
                        begin
                            if (fill_b_reg < FILL_CAP)
                            begin
                                we_b        = 1'b1;
                                fill_b_next = fill_b_reg + 1'b1;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        ACT_REPORT:
                        begin
                            rep_a_next  = '0;
                            rep_b_next  = '0;
                            common_next = '0;
                            i_next      = '0;
                            if (fill_a_reg != '0)
                            begin
                                phase_next = 1'b0;
                                state_next = ST_FETCH;
                            end
                            else if (fill_b_reg != '0)
                            begin
                                phase_next = 1'b1;
                                state_next = ST_FETCH;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                src_next   = phase_reg;
                state_next = ST_FWAIT;
            end
            ST_FWAIT:
            begin
                key_next   = rdata_sel;
                j_next     = '0;
                lim_next   = i_reg;
                cnt_next   = '0;
                pend_next  = 1'b0;
                state_next = ST_SCAN_SELF;
            end
            ST_SCAN_SELF, ST_SCAN_OTHER:
            begin
                // Count matches of the held key; data lags the address by the store's read register.
                if (pend_reg && (rdata_sel == key_reg))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (j_reg < lim_reg)
                begin
                    pend_next = 1'b1;
                    j_next    = j_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (scan_end)
                begin
                    if ((state_reg == ST_SCAN_SELF) && !phase_reg)
                    begin
                        // Occurrence rank known; count this key in the second set.
                        rank_next  = cnt_reg;
                        j_next     = '0;
                        lim_next   = fill_b_reg;
                        src_next   = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_SCAN_OTHER;
                    end
                    else
                    begin
                        if (state_reg == ST_SCAN_OTHER)
                        begin
                            // The k-th copy matches if the other set holds more than k.
                            if (cnt_reg > rank_reg)
                            begin
                                common_next = common_reg + 1'b1;
                            end
                            if (rank_reg != '0)
                            begin
                                rep_a_next = rep_a_reg + 1'b1;
                            end
                        end
                        else if (cnt_reg != '0)
                        begin
                            rep_b_next = rep_b_reg + 1'b1;
                        end
                        // Advance to the next key, or to the next set.
                        if (last_item)
                        begin
                            if (!phase_reg && (fill_b_reg != '0))
                            begin
                                phase_next = 1'b1;
                                i_next     = '0;
                                state_next = ST_FETCH;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_FETCH;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                // Result is on the ports this cycle; drop both sets.
                fill_a_next = '0;
                fill_b_next = '0;
                drop_next   = 1'b0;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = (state_reg == ST_DONE);
    assign first_size     = 11'(fill_a_reg);
    assign second_size    = 11'(fill_b_reg);
    assign first_repeats  = 10'(rep_a_reg);
    assign second_repeats = 10'(rep_b_reg);
    assign common_count   = 11'(common_reg);
    assign overflow_seen  = drop_reg;

    `SIC_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, (fill_a_reg <= FILL_CAP) && (fill_b_reg <= FILL_CAP))
    `SIC_ASSERT_NXT(a_done_clears, clk, rst_n, done, (fill_a_reg == '0) && (fill_b_reg == '0) && !drop_reg)
    `SIC_ASSERT_NXT(a_report_busy, clk, rst_n, start && !busy && (action == ACT_REPORT), busy)
    `SIC_ASSERT_IMP(a_common_bound, clk, rst_n, done, (common_reg <= fill_a_reg) && (common_reg <= fill_b_reg))
endmodule
`default_nettype wire

### rtl/sic_ram.sv
`default_nettype none
module sic_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

### tb/tb_set_intersection_counter_core.sv
`default_nettype none
module tb_set_intersection_counter_core;
    import sic_pkg::*;

    typedef struct packed {
        logic [10:0] first_size;
        logic [10:0] second_size;
        logic [9:0]  first_repeats;
        logic [9:0]  second_repeats;
        logic [10:0] common_count;
        logic        overflow_seen;
    } tally_t;

    localparam int WATCHDOG_LIMIT = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  action = ACT_ADD_FIRST;
    logic [63:0] key_value = '0;
    logic        busy;
    logic        done;
    logic [10:0] first_size;
    logic [10:0] second_size;
    logic [9:0]  first_repeats;
    logic [9:0]  second_repeats;
    logic [10:0] common_count;
    logic        overflow_seen;

    // Shadow of the block state, updated at each accepted transfer.
    logic [63:0] first_keys[$];
    logic [63:0] second_keys[$];
    logic        keys_dropped = 1'b0;
    tally_t      pending_tallies[$];

    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;

    always #2 clk = ~clk;

    set_intersection_counter_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .key_value      (key_value),
        .done           (done),
        .first_size     (first_size),
        .second_size    (second_size),
        .first_repeats  (first_repeats),
        .second_repeats (second_repeats),
        .common_count   (common_count),
        .overflow_seen  (overflow_seen)
    );

    // Count adjacent equal pairs in a sorted list.
    function automatic int count_pairs(logic [63:0] keys[$]);
        int n;
        n = 0;
        for (int i = 1; i < keys.size(); i++)
            if (keys[i-1] == keys[i])
                n++;
        return n;
    endfunction

    // Tally one report: sort both sets, count repeats, merge for matches.
    function automatic tally_t tally_sets();
        logic [63:0] sa[$];
        logic [63:0] sb[$];
        int          ia;
        int          ib;
        int          hits;
        tally_t      t;
        sa = first_keys;
        sb = second_keys;
        sa.sort();
        sb.sort();
        ia = 0;
        ib = 0;
        hits = 0;
        while (ia < sa.size() && ib < sb.size())
        begin
            if (sa[ia] == sb[ib])
            begin
                ia++;
                ib++;
                hits++;
            end
            else if (sa[ia] < sb[ib])
                ia++;
            else
                ib++;
        end
        t.first_size     = 11'(sa.size());
        t.second_size    = 11'(sb.size());
        t.first_repeats  = 10'(count_pairs(sa));
        t.second_repeats = 10'(count_pairs(sb));
        t.common_count   = 11'(hits);
        t.overflow_seen  = keys_dropped;
        return t;
    endfunction

    // Apply one accepted command to the shadow state.
    function automatic void apply_command(logic [1:0] act, logic [63:0] key);
        if (act == ACT_ADD_FIRST)
        begin
            if (first_keys.size() < CAPACITY)
                first_keys.push_back(key);
            else
                keys_dropped = 1'b1;
        end
        else if (act == ACT_ADD_SECOND)
        begin
            if (second_keys.size() < CAPACITY)
                second_keys.push_back(key);
            else
                keys_dropped = 1'b1;
        end
        else if (act == ACT_REPORT)
        begin
            pending_tallies.push_back(tally_sets());
            first_keys.delete();
            second_keys.delete();
            keys_dropped = 1'b0;
        end
    endfunction

    // Mix of a small pool (to make matches and repeats), extremes and wide keys.
    function automatic logic [63:0] pick_key();
        case ($urandom_range(3))
            0: return 64'($urandom_range(15));
            1: return 64'($urandom_range(3)) << 62 | 64'($urandom_range(7));
            2: return $urandom_range(1) ? '0 : '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Send one command; hold start high until the transfer happens.
    task automatic send_command(logic [1:0] act, logic [63:0] key);
        if (idle_on)
            while ($urandom_range(99) < 30)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start     <= 1'b1;
        action    <= act;
        key_value <= key;
        do
            @(posedge clk);
        while (busy);
        apply_command(act, key);
    endtask

    task automatic test_empty_and_extremes();
        send_command(ACT_REPORT, '1);
        send_command(ACT_ADD_FIRST, '0);
        send_command(ACT_ADD_FIRST, '1);
        send_command(ACT_ADD_FIRST, '1);
        send_command(ACT_ADD_SECOND, '1);
        send_command(ACT_ADD_SECOND, '0);
        send_command(ACT_ADD_SECOND, '0);
        send_command(2'd3, 64'h5555_5555_5555_5555);
        send_command(ACT_REPORT, 64'hAAAA_AAAA_AAAA_AAAA);
        // One set empty, the other not: merge finds nothing.
        send_command(ACT_ADD_SECOND, 64'd7);
        send_command(ACT_ADD_SECOND, 64'd7);
        send_command(ACT_REPORT, '0);
        send_command(ACT_ADD_FIRST, 64'd9);
        send_command(ACT_REPORT, '0);
    endtask

    // Fill the first set past capacity; the extra key is dropped and flagged.
    task automatic test_full_set();
        for (int i = 0; i <= CAPACITY; i++)
            send_command(ACT_ADD_FIRST, 64'($urandom_range(300)));
        send_command(ACT_ADD_SECOND, 64'd5);
        send_command(ACT_REPORT, '0);
    endtask

    task automatic test_random_batches();
        int sent;
        int na;
        int nb;
        sent = 0;
        while (sent < 300)
        begin
            // Run a stretch with no idling at all.
            idle_on = !(sent > 100 && sent < 200);
            na = $urandom_range(12);
            nb = $urandom_range(12);
            while (na + nb > 0)
            begin
                if ($urandom_range(19) == 0)
                    send_command(2'd3, pick_key());
                else if (na > 0 && (nb == 0 || $urandom_range(1)))
                begin
                    send_command(ACT_ADD_FIRST, pick_key());
                    na--;
                end
                else
                begin
                    send_command(ACT_ADD_SECOND, pick_key());
                    nb--;
                end
                sent++;
            end
            send_command(ACT_REPORT, pick_key());
            sent++;
        end
    endtask

    // Compare each result with the oldest tally waiting.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_tallies.size() == 0)
            begin
                $error("result with no tally waiting");
                mismatches++;
            end
            else
            begin
                tally_t t;
                t = pending_tallies.pop_front();
                if (first_size !== t.first_size)
                begin
                    $error("first_size exp %0d got %0d", t.first_size, first_size);
                    mismatches++;
                end
                if (second_size !== t.second_size)
                begin
                    $error("second_size exp %0d got %0d", t.second_size, second_size);
                    mismatches++;
                end
                if (first_repeats !== t.first_repeats)
                begin
                    $error("first_repeats exp %0d got %0d", t.first_repeats,
                           first_repeats);
                    mismatches++;
                end
                if (second_repeats !== t.second_repeats)
                begin
                    $error("second_repeats exp %0d got %0d", t.second_repeats,
                           second_repeats);
                    mismatches++;
                end
                if (common_count !== t.common_count)
                begin
                    $error("common_count exp %0d got %0d", t.common_count,
                           common_count);
                    mismatches++;
                end
                if (overflow_seen !== t.overflow_seen)
                begin
                    $error("overflow_seen exp %0d got %0d", t.overflow_seen,
                           overflow_seen);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run as a mismatch when the block stays quiet.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int drain;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_extremes();
        test_full_set();
        test_random_batches();
        @(posedge clk);
        start <= 1'b0;
        // Drain: wait for every tally, then a short settle.
        drain = 0;
        while ((pending_tallies.size() != 0 || busy) && drain < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_tallies.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

### set_intersection_counter_core.f
+incdir+rtl
rtl/sic_pkg.sv
rtl/sic_ram.sv
rtl/set_intersection_counter_core.sv
tb/tb_set_intersection_counter_core.sv
